>>> hdl/tfp_pkg.sv
// ----------------------------------------------------------------------------
// tfp_pkg: shared types, widths and helpers for triangle_from_points
// Coordinate width drives every other width in the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tfp_pkg;

  localparam int COORD_WIDTH = 16;

  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;       // vertex difference
  localparam int SUM_WIDTH   = COORD_WIDTH + 2;       // sum of three coords
  localparam int SQR_WIDTH   = 2 * COORD_WIDTH;       // one squared difference
  localparam int SQ_WIDTH    = 2 * COORD_WIDTH + 1;   // squared distance
  localparam int ROOT_WIDTH  = COORD_WIDTH + 1;       // side length
  localparam int TRIAL_WIDTH = 2 * COORD_WIDTH + 3;   // root trial term
  localparam int PERIM_WIDTH = COORD_WIDTH + 3;
  localparam int AREA_WIDTH  = 2 * COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
  localparam int CROSS_WIDTH = PROD_WIDTH + 1;
  localparam int MAG_WIDTH   = COORD_WIDTH + 1;       // |sum of coords|

  // divide by three: q = (m * RECIP) >> SHIFT, exact for m < 2^(COORD_WIDTH+1)
  localparam int DIV3_SHIFT  = COORD_WIDTH + 2;
  localparam logic [DIV3_SHIFT-1:0] DIV3_RECIP =
    DIV3_SHIFT'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);
  localparam int QPROD_WIDTH = MAG_WIDTH + DIV3_SHIFT;

  localparam int SIDE_AB = 0;
  localparam int SIDE_AC = 1;
  localparam int SIDE_BC = 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by_coord;
    coord_t cx;
    coord_t cy;
  } vertices_t;

  typedef struct packed {
    logic [AREA_WIDTH-1:0] area;
    coord_t                gx;
    coord_t                gy;
  } side_t;

  typedef struct packed {
    logic [2:0][SQ_WIDTH-1:0] sq;
    side_t                    side;
  } mid_t;

  typedef struct packed {
    logic [2:0][SQ_WIDTH-1:0]   rem;
    logic [2:0][ROOT_WIDTH-1:0] root;
    side_t                      side;
  } root_stage_t;

  typedef struct packed {
    logic [2:0][ROOT_WIDTH-1:0] root;
    side_t                      side;
  } root_out_t;

  typedef struct packed {
    logic                   is_triangle;
    logic [PERIM_WIDTH-1:0] perimeter;
    logic [AREA_WIDTH-1:0]  double_area;
    coord_t                 centroid_x;
    coord_t                 centroid_y;
  } result_t;

  typedef struct packed {
    logic [SQ_WIDTH-1:0]   rem;
    logic [ROOT_WIDTH-1:0] root;
  } sqrt_step_t;

  // One digit of the restoring square root: rem = v - root^2 on entry,
  // root holds only the bits above bit_pos.
  function automatic sqrt_step_t sqrt_step(input logic [SQ_WIDTH-1:0] rem,
                                           input logic [ROOT_WIDTH-1:0] root,
                                           input int unsigned bit_pos);
    logic [TRIAL_WIDTH-1:0] trial;
    sqrt_step_t             res;
    trial = (TRIAL_WIDTH'(root) << (bit_pos + 1)) + (TRIAL_WIDTH'(1) << (2 * bit_pos));
    if (TRIAL_WIDTH'(rem) >= trial) begin
      res.rem  = rem - trial[SQ_WIDTH-1:0];
      res.root = root | (ROOT_WIDTH'(1) << bit_pos);
    end else begin
      res.rem  = rem;
      res.root = root;
    end
    return res;
  endfunction

endpackage

>>> hdl/tfp_front.sv
// ----------------------------------------------------------------------------
// tfp_front: differences, squares, cross product and centroid
// Four register stages: diff/sum, multiply, add/reciprocal, abs/negate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfp_front import tfp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  vertices_t vtx,
  output logic      out_valid,
  output mid_t      out_data
);

  logic [3:0] vld;

  // stage 1
  logic signed [DIFF_WIDTH-1:0] ab_x, ab_y, ac_x, ac_y, bc_x, bc_y;
  logic signed [SUM_WIDTH-1:0]  sum_x, sum_y;

  // stage 2
  logic signed [PROD_WIDTH-1:0] p_abx, p_aby, p_acx, p_acy, p_bcx, p_bcy;
  logic signed [PROD_WIDTH-1:0] p_x1, p_x2;
  logic [SQR_WIDTH-1:0]         sq_abx, sq_aby, sq_acx, sq_acy, sq_bcx, sq_bcy;
  logic signed [PROD_WIDTH-1:0] x1, x2;
  logic [MAG_WIDTH-1:0]         mag_x, mag_y;
  logic                         neg2_x, neg2_y;

  // stage 3
  logic [2:0][SQ_WIDTH-1:0]      sq;
  logic signed [CROSS_WIDTH-1:0] cross_prod;
  logic [QPROD_WIDTH-1:0]        qp_x, qp_y;
  logic                          neg3_x, neg3_y;

  // stage 4 helpers
  logic [COORD_WIDTH-1:0] q_x, q_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_comb begin
    p_abx = ab_x * ab_x;
    p_aby = ab_y * ab_y;
    p_acx = ac_x * ac_x;
    p_acy = ac_y * ac_y;
    p_bcx = bc_x * bc_x;
    p_bcy = bc_y * bc_y;
    p_x1  = ab_x * ac_y;
    p_x2  = ac_x * ab_y;
    q_x   = qp_x[DIV3_SHIFT +: COORD_WIDTH];
    q_y   = qp_y[DIV3_SHIFT +: COORD_WIDTH];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      ab_x  <= DIFF_WIDTH'(vtx.bx) - DIFF_WIDTH'(vtx.ax);
      ab_y  <= DIFF_WIDTH'(vtx.by_coord) - DIFF_WIDTH'(vtx.ay);
      ac_x  <= DIFF_WIDTH'(vtx.cx) - DIFF_WIDTH'(vtx.ax);
      ac_y  <= DIFF_WIDTH'(vtx.cy) - DIFF_WIDTH'(vtx.ay);
      bc_x  <= DIFF_WIDTH'(vtx.cx) - DIFF_WIDTH'(vtx.bx);
      bc_y  <= DIFF_WIDTH'(vtx.cy) - DIFF_WIDTH'(vtx.by_coord);
      sum_x <= SUM_WIDTH'(vtx.ax) + SUM_WIDTH'(vtx.bx) + SUM_WIDTH'(vtx.cx);
      sum_y <= SUM_WIDTH'(vtx.ay) + SUM_WIDTH'(vtx.by_coord) + SUM_WIDTH'(vtx.cy);

      // stage 2
      sq_abx <= p_abx[SQR_WIDTH-1:0];
      sq_aby <= p_aby[SQR_WIDTH-1:0];
      sq_acx <= p_acx[SQR_WIDTH-1:0];
      sq_acy <= p_acy[SQR_WIDTH-1:0];
      sq_bcx <= p_bcx[SQR_WIDTH-1:0];
      sq_bcy <= p_bcy[SQR_WIDTH-1:0];
      x1     <= p_x1;
      x2     <= p_x2;
      mag_x  <= sum_x[SUM_WIDTH-1] ? MAG_WIDTH'(-sum_x) : MAG_WIDTH'(sum_x);
      mag_y  <= sum_y[SUM_WIDTH-1] ? MAG_WIDTH'(-sum_y) : MAG_WIDTH'(sum_y);
      neg2_x <= sum_x[SUM_WIDTH-1];
      neg2_y <= sum_y[SUM_WIDTH-1];

      // stage 3
      sq[SIDE_AB] <= SQ_WIDTH'(sq_abx) + SQ_WIDTH'(sq_aby);
      sq[SIDE_AC] <= SQ_WIDTH'(sq_acx) + SQ_WIDTH'(sq_acy);
      sq[SIDE_BC] <= SQ_WIDTH'(sq_bcx) + SQ_WIDTH'(sq_bcy);
      cross_prod  <= CROSS_WIDTH'(x1) - CROSS_WIDTH'(x2);
      qp_x        <= QPROD_WIDTH'(mag_x) * QPROD_WIDTH'(DIV3_RECIP);
      qp_y        <= QPROD_WIDTH'(mag_y) * QPROD_WIDTH'(DIV3_RECIP);
      neg3_x      <= neg2_x;
      neg3_y      <= neg2_y;

      // stage 4
      out_data.sq        <= sq;
      out_data.side.area <= cross_prod[CROSS_WIDTH-1] ? AREA_WIDTH'(-cross_prod)
                                                      : AREA_WIDTH'(cross_prod);
      out_data.side.gx   <= neg3_x ? (COORD_WIDTH'(0) - q_x) : q_x;
      out_data.side.gy   <= neg3_y ? (COORD_WIDTH'(0) - q_y) : q_y;
    end
  end

  assign out_valid = vld[3];

endmodule

>>> hdl/tfp_root_pipe.sv
// ----------------------------------------------------------------------------
// tfp_root_pipe: three-lane pipelined integer square root
// One result bit per stage, MSB first; side data rides alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfp_root_pipe import tfp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  mid_t      in_data,
  output logic      out_valid,
  output root_out_t out_data
);

  root_stage_t           st [ROOT_WIDTH];
  logic [ROOT_WIDTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ROOT_WIDTH-2:0], in_valid};
    end
  end

  for (genvar g = 0; g < ROOT_WIDTH; g++) begin : g_stage
    root_stage_t prev;
    root_stage_t nxt;

    if (g == 0) begin : g_first
      always_comb begin
        prev.rem  = in_data.sq;
        prev.root = '0;
        prev.side = in_data.side;
      end
    end else begin : g_rest
      assign prev = st[g-1];
    end

    always_comb begin
      sqrt_step_t s;
      nxt.side = prev.side;
      for (int k = 0; k < 3; k++) begin
        s           = sqrt_step(prev.rem[k], prev.root[k], ROOT_WIDTH - 1 - g);
        nxt.rem[k]  = s.rem;
        nxt.root[k] = s.root;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[g] <= nxt;
      end
    end
  end

  assign out_valid     = vld[ROOT_WIDTH-1];
  assign out_data.root = st[ROOT_WIDTH-1].root;
  assign out_data.side = st[ROOT_WIDTH-1].side;

endmodule

>>> hdl/tfp_back.sv
// ----------------------------------------------------------------------------
// tfp_back: perimeter, longest side and triangle test
// Two stages: sum/max, then strict inequality.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfp_back import tfp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  root_out_t in_data,
  output logic      out_valid,
  output result_t   out_data
);

  logic [1:0]             vld;
  logic [ROOT_WIDTH-1:0]  max_ab;
  logic [ROOT_WIDTH-1:0]  longest_next;
  logic [PERIM_WIDTH-1:0] total;
  logic [ROOT_WIDTH-1:0]  longest;
  side_t                  side;

  always_comb begin
    max_ab = (in_data.root[SIDE_AC] > in_data.root[SIDE_AB]) ?
             in_data.root[SIDE_AC] : in_data.root[SIDE_AB];
    longest_next = (in_data.root[SIDE_BC] > max_ab) ? in_data.root[SIDE_BC] : max_ab;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      total   <= PERIM_WIDTH'(in_data.root[SIDE_AB]) + PERIM_WIDTH'(in_data.root[SIDE_AC])
               + PERIM_WIDTH'(in_data.root[SIDE_BC]);
      longest <= longest_next;
      side    <= in_data.side;

      out_data.is_triangle <= (total - PERIM_WIDTH'(longest)) > PERIM_WIDTH'(longest);
      out_data.perimeter   <= total;
      out_data.double_area <= side.area;
      out_data.centroid_x  <= side.gx;
      out_data.centroid_y  <= side.gy;
    end
  end

  assign out_valid = vld[1];

endmodule

>>> hdl/tfp_skid.sv
// ----------------------------------------------------------------------------
// tfp_skid: output register with one skid entry
// Upstream ready is registered, so the pipeline never sees out_ready directly.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfp_skid import tfp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    take;

  assign take     = out_valid && out_ready;
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take || !out_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (in_valid) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take || !out_valid) begin
        out_data <= skid_data;
      end
    end else if (in_valid) begin
      if (!out_valid || take) begin
        out_data <= in_data;
      end else begin
        skid_data <= in_data;
      end
    end
  end

endmodule

>>> hdl/triangle_from_points.sv
// ----------------------------------------------------------------------------
// triangle_from_points: side lengths, triangle test, area and centroid
// Depth: 24 register stages (4 front, 17 root, 2 back, 1 output); the root
// depth is COORD_WIDTH + 1, one result bit per stage.
// Throughput: one transfer per cycle while the output is taken.
// Reset clears only valid bits; payload registers are left as they are.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Dataflow:
//   tfp_front     - vertex differences, squared distances, |AB x AC|,
//                   centroid via reciprocal multiply (truncates toward zero)
//   tfp_root_pipe - floor square root of the three squared distances
//   tfp_back      - perimeter, longest side, strict triangle inequality
//   tfp_skid      - output register plus skid entry
// The whole pipeline advances on one enable, which is the skid's registered
// ready. A stall freezes every stage in place, so nothing is lost or doubled.

module triangle_from_points import tfp_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] ax,
  input  logic signed [COORD_WIDTH-1:0] ay,
  input  logic signed [COORD_WIDTH-1:0] bx,
  input  logic signed [COORD_WIDTH-1:0] by_coord,
  input  logic signed [COORD_WIDTH-1:0] cx,
  input  logic signed [COORD_WIDTH-1:0] cy,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          is_triangle,
  output logic [PERIM_WIDTH-1:0]        perimeter,
  output logic [AREA_WIDTH-1:0]         double_area,
  output logic signed [COORD_WIDTH-1:0] centroid_x,
  output logic signed [COORD_WIDTH-1:0] centroid_y
);

  logic      en;          // pipeline advance
  vertices_t vtx;

  logic      front_valid;
  mid_t      front_data;
  logic      root_valid;
  root_out_t root_data;
  logic      back_valid;
  result_t   back_data;
  result_t   res;

  // input transfer happens whenever the pipeline advances
  assign in_ready = en;

  assign vtx.ax       = ax;
  assign vtx.ay       = ay;
  assign vtx.bx       = bx;
  assign vtx.by_coord = by_coord;
  assign vtx.cx       = cx;
  assign vtx.cy       = cy;

  tfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .vtx       (vtx),
    .out_valid (front_valid),
    .out_data  (front_data)
  );

  tfp_root_pipe u_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .in_data   (front_data),
    .out_valid (root_valid),
    .out_data  (root_data)
  );

  tfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (root_valid),
    .in_data   (root_data),
    .out_valid (back_valid),
    .out_data  (back_data)
  );

  // skid ready only drops once a result is parked, and it is registered
  tfp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (back_valid && en),
    .in_ready  (en),
    .in_data   (back_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (res)
  );

  assign is_triangle = res.is_triangle;
  assign perimeter   = res.perimeter;
  assign double_area = res.double_area;
  assign centroid_x  = res.centroid_x;
  assign centroid_y  = res.centroid_y;

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for triangle_from_points
// Drives vertex triples over valid/ready with random gaps on both sides,
// predicts side lengths, triangle flag, perimeter, twice the area and the
// centroid where the table gives none, and checks each output transfer in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import tfp_pkg::*;

  localparam int N_RANDOM     = 1800;
  localparam int DRAIN_CYCLES = 40;    // pipeline is 24 stages plus the skid entry
  localparam int STALL_LIMIT  = 2000;  // cycles with no transfer on either side
  localparam int CMIN         = -(2 ** (COORD_WIDTH - 1));
  localparam int CMAX         = 2 ** (COORD_WIDTH - 1) - 1;

  // one row of the directed table; res is only meaningful when known is set
  typedef struct packed {
    vertices_t pts;
    logic      known;
    result_t   res;
  } stim_row_t;

  logic   clk;
  logic   rst       = 1'b1;
  logic   in_valid  = 1'b0;
  logic   out_ready = 1'b0;
  coord_t ax        = '0;
  coord_t ay        = '0;
  coord_t bx        = '0;
  coord_t by_coord  = '0;
  coord_t cx        = '0;
  coord_t cy        = '0;

  logic                   in_ready;
  logic                   out_valid;
  logic                   is_triangle;
  logic [PERIM_WIDTH-1:0] perimeter;
  logic [AREA_WIDTH-1:0]  double_area;
  coord_t                 centroid_x;
  coord_t                 centroid_y;

  result_t pending_measures [$];  // expected results, oldest first
  int      mismatch_count = 0;
  int      results_taken  = 0;

  triangle_from_points u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .ax          (ax),
    .ay          (ay),
    .bx          (bx),
    .by_coord    (by_coord),
    .cx          (cx),
    .cy          (cy),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .is_triangle (is_triangle),
    .perimeter   (perimeter),
    .double_area (double_area),
    .centroid_x  (centroid_x),
    .centroid_y  (centroid_y)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // floor square root, one result bit at a time from the top; the largest
  // squared distance is below 2^34, so the root fits in 17 bits
  function automatic longint floor_root(input longint v);
    longint root;
    longint trial;
    root = 0;
    for (int b = 17; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic longint side_length(input longint x0, input longint y0,
                                         input longint x1, input longint y1);
    return floor_root((x1 - x0) * (x1 - x0) + (y1 - y0) * (y1 - y0));
  endfunction

  function automatic result_t predict_measures(input vertices_t p);
    longint  xa, ya, xb, yb, xc, yc;
    longint  s_ab, s_ac, s_bc, longest, total, cross_val;
    result_t r;
    xa = $signed(p.ax);
    ya = $signed(p.ay);
    xb = $signed(p.bx);
    yb = $signed(p.by_coord);
    xc = $signed(p.cx);
    yc = $signed(p.cy);
    s_ab = side_length(xa, ya, xb, yb);
    s_ac = side_length(xa, ya, xc, yc);
    s_bc = side_length(xb, yb, xc, yc);
    longest = s_ab;
    if (s_ac > longest) longest = s_ac;
    if (s_bc > longest) longest = s_bc;
    total = s_ab + s_ac + s_bc;
    // strict inequality on the floored sides: the two shorter beat the longest
    r.is_triangle = (total - longest) > longest;
    r.perimeter   = total[PERIM_WIDTH-1:0];
    // magnitude of AB x AC, so vertex order does not matter
    cross_val = (xb - xa) * (yc - ya) - (xc - xa) * (yb - ya);
    if (cross_val < 0) cross_val = -cross_val;
    r.double_area = cross_val[AREA_WIDTH-1:0];
    // signed division truncates toward zero
    r.centroid_x  = coord_t'((xa + xb + xc) / 3);
    r.centroid_y  = coord_t'((ya + yb + yc) / 3);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic stim_row_t stim_row(input int pax, input int pay, input int pbx,
                                         input int pby, input int pcx, input int pcy,
                                         input bit known = 1'b0, input bit tri_flag = 1'b0,
                                         input int perim = 0, input longint area = 0,
                                         input int gx = 0, input int gy = 0);
    stim_row_t s;
    s.pts.ax            = coord_t'(pax);
    s.pts.ay            = coord_t'(pay);
    s.pts.bx            = coord_t'(pbx);
    s.pts.by_coord      = coord_t'(pby);
    s.pts.cx            = coord_t'(pcx);
    s.pts.cy            = coord_t'(pcy);
    s.known             = known;
    s.res.is_triangle   = tri_flag;
    s.res.perimeter     = PERIM_WIDTH'(perim);
    s.res.double_area   = AREA_WIDTH'(area);
    s.res.centroid_x    = coord_t'(gx);
    s.res.centroid_y    = coord_t'(gy);
    return s;
  endfunction

  function automatic coord_t sat(input int v);
    if (v < CMIN) return coord_t'(CMIN);
    if (v > CMAX) return coord_t'(CMAX);
    return coord_t'(v);
  endfunction

  function automatic int spread(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(0, 2 * CMAX + 1)) + CMIN;
  endfunction

  function automatic coord_t pick_extreme();
    int v;
    case ($urandom_range(0, 5))
      0:       v = CMIN;
      1:       v = CMAX;
      2:       v = 0;
      3:       v = -1;
      4:       v = 1;
      default: v = spread(2);
    endcase
    return coord_t'(v);
  endfunction

  // full-range triples (about a third), plus small, extreme and 3-4-5 shapes and shapes near the flag boundary
  function automatic vertices_t random_vertices();
    vertices_t p;
    int        kind, x0, y0, dx, dy, k, span;
    kind = $urandom_range(0, 99);
    x0   = any_coord();
    y0   = any_coord();
    if (kind < 35) begin
      p = vertices_t'({$urandom, $urandom, $urandom});
    end else if (kind < 60) begin
      // small triangle somewhere in the plane
      span       = ($urandom_range(0, 3) == 0) ? 20 : 2000;
      p.ax       = sat(x0 + spread(span));
      p.ay       = sat(y0 + spread(span));
      p.bx       = sat(x0 + spread(span));
      p.by_coord = sat(y0 + spread(span));
      p.cx       = sat(x0 + spread(span));
      p.cy       = sat(y0 + spread(span));
    end else if (kind < 72) begin
      // collinear, or nudged one unit off the line (flat but not degenerate)
      x0         = spread(1000);
      y0         = spread(1000);
      dx         = spread(300);
      dy         = spread(300);
      k          = spread(6);
      p.ax       = sat(x0);
      p.ay       = sat(y0);
      p.bx       = sat(x0 + dx);
      p.by_coord = sat(y0 + dy);
      p.cx       = sat(x0 + k * dx + spread(1));
      p.cy       = sat(y0 + k * dy + spread(1));
    end else if (kind < 82) begin
      // coincident vertices
      p = vertices_t'({$urandom, $urandom, $urandom});
      case ($urandom_range(0, 3))
        0:       begin p.bx = p.ax; p.by_coord = p.ay; end
        1:       begin p.cx = p.ax; p.cy = p.ay; end
        2:       begin p.cx = p.bx; p.cy = p.by_coord; end
        default: begin p.bx = p.ax; p.by_coord = p.ay; p.cx = p.ax; p.cy = p.ay; end
      endcase
    end else if (kind < 92) begin
      p.ax       = pick_extreme();
      p.ay       = pick_extreme();
      p.bx       = pick_extreme();
      p.by_coord = pick_extreme();
      p.cx       = pick_extreme();
      p.cy       = pick_extreme();
    end else begin
      // scaled 3-4-5 right triangle, random orientation
      k          = $urandom_range(1, 8000);
      dx         = $urandom_range(0, 1) ? 3 * k : -3 * k;
      dy         = $urandom_range(0, 1) ? 4 * k : -4 * k;
      p.ax       = sat(x0);
      p.ay       = sat(y0);
      p.bx       = sat(x0 + dx);
      p.by_coord = sat(y0);
      p.cx       = sat(x0);
      p.cy       = sat(y0 + dy);
    end
    return p;
  endfunction

  // idle gap before a transfer: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Offer one triple and hold it until the transfer. in_valid only drops when
  // a gap is wanted, so back-to-back items keep it high without a glitch.
  task automatic offer_item(input vertices_t p, input result_t want, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ax       <= p.ax;
    ay       <= p.ay;
    bx       <= p.bx;
    by_coord <= p.by_coord;
    cx       <= p.cx;
    cy       <= p.cy;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_measures.push_back(want);
  endtask

  // --------------------------------------------------------------------------
  // Sender: directed table, then random triples
  // --------------------------------------------------------------------------
  initial begin : vertex_source
    stim_row_t dir_table [$];
    result_t   want;
    vertices_t p;
    int        gap;
    // known rows: point triangles at origin and at both corners, 3-4-5 both
    // windings, a straight line, a doubled vertex, centroid rounding of
    // negative sums; the rest go to the predictor
    dir_table = '{
      stim_row(0, 0, 0, 0, 0, 0,                        1, 0, 0, 0, 0, 0),
      stim_row(32767, 32767, 32767, 32767, 32767, 32767, 1, 0, 0, 0, 32767, 32767),
      stim_row(-32768, -32768, -32768, -32768, -32768, -32768,
               1, 0, 0, 0, -32768, -32768),
      stim_row(0, 0, 3, 0, 0, 4,                        1, 1, 12, 12, 1, 1),
      stim_row(0, 0, 0, 4, 3, 0,                        1, 1, 12, 12, 1, 1),
      stim_row(0, 0, 3, 0, 6, 0,                        1, 0, 12, 0, 3, 0),
      stim_row(5, 5, 5, 5, 8, 9,                        1, 0, 10, 0, 6, 6),
      stim_row(-1, -2, 0, 0, 0, 0,                      1, 0, 4, 0, 0, 0),
      stim_row(-4, -5, 0, 0, 0, 0,                      1, 0, 12, 0, -1, -1),
      stim_row(-32768, -32768, 32767, -32768, -32768, 32767),
      stim_row(32767, 32767, -32768, 32767, 32767, -32768),
      stim_row(-32768, 32767, 32767, -32768, 32767, 32767),
      stim_row(-32768, 32767, 32767, -32768, 0, 0),
      stim_row(-32768, 0, 32767, 0, 0, 32767),
      stim_row(21845, -21846, -21846, 21845, 21845, 21845),
      stim_row(-21846, 21845, 21845, -21846, -21846, -21846),
      stim_row(0, 0, 10, 0, 5, 9),
      stim_row(0, 0, 100, 0, 200, 1),
      stim_row(0, 0, 1, 1, 2, 2),
      stim_row(1, 0, 0, 1, 0, 0),
      stim_row(-32768, -32768, 32767, 32767, -32768, 32767)
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) begin
      want = dir_table[i].known ? dir_table[i].res : predict_measures(dir_table[i].pts);
      offer_item(dir_table[i].pts, want, (i % 4 == 3) ? pick_gap() : 0);
    end

    // every third block of 200 runs with no sender gaps
    for (int i = 0; i < N_RANDOM; i++) begin
      p   = random_vertices();
      gap = ((i / 200) % 3 == 1) ? 0 : pick_gap();
      offer_item(p, predict_measures(p), gap);
    end
    in_valid <= 1'b0;

    while (pending_measures.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random backpressure, plus two long hold-offs so the pipeline
  // fills and in_ready drops while the sender keeps offering
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int r;
    int hold;
    int holds_done;
    holds_done = 0;
    while (rst) @(posedge clk);
    forever begin
      if (holds_done < 2 && results_taken >= 150 + 700 * holds_done) begin
        out_ready <= 1'b0;
        hold       = 100;
        holds_done++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          out_ready <= 1'b1;
          hold = $urandom_range(30, 80);
        end else if (r < 65) begin
          out_ready <= 1'b1;
          hold = $urandom_range(1, 6);
        end else if (r < 90) begin
          out_ready <= 1'b0;
          hold = $urandom_range(1, 3);
        end else if (r < 98) begin
          out_ready <= 1'b0;
          hold = $urandom_range(4, 12);
        end else begin
          out_ready <= 1'b0;
          hold = $urandom_range(20, 45);
        end
      end
      repeat (hold) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Checker: each output transfer against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      results_taken++;
      if (pending_measures.size() == 0) begin
        report_mismatch("output transfer with no input outstanding");
      end else begin
        want = pending_measures.pop_front();
        if (is_triangle !== want.is_triangle)
          report_mismatch($sformatf("is_triangle got %0b want %0b",
                                    is_triangle, want.is_triangle));
        if (perimeter !== want.perimeter)
          report_mismatch($sformatf("perimeter got %0d want %0d",
                                    perimeter, want.perimeter));
        if (double_area !== want.double_area)
          report_mismatch($sformatf("double_area got %0d want %0d",
                                    double_area, want.double_area));
        if (centroid_x !== want.centroid_x)
          report_mismatch($sformatf("centroid_x got %0d want %0d",
                                    centroid_x, want.centroid_x));
        if (centroid_y !== want.centroid_y)
          report_mismatch($sformatf("centroid_y got %0d want %0d",
                                    centroid_y, want.centroid_y));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run if neither side transfers for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

endmodule
